>>> hdl/cde_pkg.sv
// Shared types, codes and constants of the column digest engine.
// Used by the shift-add unit and the core.
`default_nettype none

package cde_pkg;

   // column type register codes
   typedef enum logic [1:0] {
      COL_INT32  = 2'd0,
      COL_INT64  = 2'd1,
      COL_DOUBLE = 2'd2,
      COL_BYTES  = 2'd3
   } col_type_type;

   // input item op codes
   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_ROW    = 2'd1,
      OP_HEADER = 2'd2,
      OP_BYTE   = 2'd3
   } op_type;

   localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
   localparam logic [7:0]  BYTE_MASK = 8'hFF;

   // FNV prime = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0: one shifted add per set bit
   localparam int          FNV_STEPS = 7;
   localparam logic [5:0]  FNV_SHIFT [FNV_STEPS] = '{6'd0, 6'd1, 6'd4, 6'd5, 6'd7, 6'd8, 6'd40};

   // bytes of the string length folded by a header
   localparam int          LEN_BYTES = 4;

   typedef struct packed {
      logic       xor_mode;   // 1: a ^ (b << shift), 0: a + (b << shift)
      logic [5:0] shift;
   } unit_ctrl_type;

endpackage

`default_nettype wire

>>> hdl/cde_req_if.sv
// Input item channel of the column digest engine: valid/ready plus item fields.
// Standalone; no package dependency.
`default_nettype none

interface cde_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic        row_valid;
   logic [63:0] value;
   logic [31:0] string_length;
   logic [7:0]  data_byte;

   modport source (output valid, output op, output row_valid, output value,
                   output string_length, output data_byte, input ready);
   modport sink   (input valid, input op, input row_valid, input value,
                   input string_length, input data_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/cde_rsp_if.sv
// Result channel of the column digest engine: valid/ready plus digest fields.
// Standalone; no package dependency.
`default_nettype none

interface cde_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest;
   logic        item_ignored;

   modport source (output valid, output digest, output item_ignored, input ready);
   modport sink   (input valid, input digest, input item_ignored, output ready);
endinterface

`default_nettype wire

>>> hdl/column_digest_engine_core.sv
// Column digest engine: running 64-bit sum / xor / FNV-1a 64 over one column.
// A request is captured in ST_IDLE, handled in ST_EXEC, multiplied in ST_MUL for a
// string byte or valid string header, then registered as the response in ST_EMIT
// once the response register is free; the next request is taken only after that.
// FNV steps run 7 shifted adds each on one shared 64-bit adder. Synchronous reset
// clears the accumulator, column type, null-row skip flag, state and response valid.
`default_nettype none

module column_digest_engine_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data,
   cde_req_if.sink         req_chan,
   cde_rsp_if.source       rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_EMIT
   } state_type;

   localparam logic [2:0] LAST_STEP = 3'(cde_pkg::FNV_STEPS - 1);
   localparam logic [1:0] LAST_LEN  = 2'(cde_pkg::LEN_BYTES - 1);

   state_type            state_ff, state_in;
   cde_pkg::col_type_type col_ff, col_in;
   logic [63:0]          acc_ff, acc_in;
   logic                 skip_ff, skip_in;

   // captured item
   cde_pkg::op_type      op_ff, op_in;
   logic                 row_valid_ff, row_valid_in;
   logic [63:0]          value_ff, value_in;
   logic [31:0]          len_ff, len_in;
   logic [7:0]           byte_ff, byte_in;

   // FNV multiply sequencer
   logic [63:0]          x_ff, x_in;
   logic [63:0]          sum_ff, sum_in;
   logic [2:0]           step_ff, step_in;
   logic [1:0]           bidx_ff, bidx_in;
   logic                 ign_ff, ign_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_digest_ff, rsp_digest_in;
   logic                 rsp_ign_ff, rsp_ign_in;

   logic [63:0]          unit_a, unit_b, unit_result;
   cde_pkg::unit_ctrl_type unit_ctrl;

   logic                 req_xfer;
   logic                 str_mode;
   logic [1:0]           bidx_next;
   logic [7:0]           len_byte_first, len_byte_next;

   cde_shift_add u_unit (
      .a      (unit_a),
      .b      (unit_b),
      .ctrl   (unit_ctrl),
      .result (unit_result)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign req_xfer            = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.digest       = rsp_digest_ff;
   assign rsp_chan.item_ignored = rsp_ign_ff;

   assign str_mode       = (col_ff == cde_pkg::COL_BYTES);
   assign bidx_next      = bidx_ff + 2'd1;
   assign len_byte_first = len_ff[7:0] & cde_pkg::BYTE_MASK;
   assign len_byte_next  = len_ff[{bidx_next, 3'b000} +: 8];

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      acc_in        = acc_ff;
      skip_in       = skip_ff;
      op_in         = op_ff;
      row_valid_in  = row_valid_ff;
      value_in      = value_ff;
      len_in        = len_ff;
      byte_in       = byte_ff;
      x_in          = x_ff;
      sum_in        = sum_ff;
      step_in       = step_ff;
      bidx_in       = bidx_ff;
      ign_in        = ign_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_digest_in = rsp_digest_ff;
      rsp_ign_in    = rsp_ign_ff;

      unit_a             = sum_ff;
      unit_b             = x_ff;
      unit_ctrl.xor_mode = 1'b0;
      unit_ctrl.shift    = cde_pkg::FNV_SHIFT[step_ff];

      if (csr_wr_en) begin
         col_in = cde_pkg::col_type_type'(csr_wr_data);
      end

      // drop the response once the sink takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in        = cde_pkg::op_type'(req_chan.op);
               row_valid_in = req_chan.row_valid;
               value_in     = req_chan.value;
               len_in       = req_chan.string_length;
               byte_in      = req_chan.data_byte;
               state_in     = ST_EXEC;
            end
         end

         ST_EXEC: begin
            ign_in   = 1'b0;
            state_in = ST_EMIT;
            step_in  = '0;
            sum_in   = '0;
            unique case (op_ff)
               cde_pkg::OP_START: begin
                  acc_in  = str_mode ? cde_pkg::FNV_BASIS : 64'd0;
                  skip_in = 1'b0;
               end
               cde_pkg::OP_ROW: begin
                  unit_a          = acc_ff;
                  unit_ctrl.shift = 6'd0;
                  unit_ctrl.xor_mode = (col_ff == cde_pkg::COL_DOUBLE);
                  if (col_ff == cde_pkg::COL_INT32) begin
                     unit_b = {{32{value_ff[31]}}, value_ff[31:0]};
                  end else begin
                     unit_b = value_ff;
                  end
                  if (str_mode || !row_valid_ff) begin
                     ign_in = 1'b1;
                  end else begin
                     acc_in = unit_result;
                  end
               end
               cde_pkg::OP_HEADER: begin
                  if (!str_mode) begin
                     ign_in = 1'b1;
                  end else if (!row_valid_ff) begin
                     skip_in = 1'b1;
                     ign_in  = 1'b1;
                  end else begin
                     skip_in  = 1'b0;
                     x_in     = acc_ff ^ {56'd0, len_byte_first};
                     bidx_in  = '0;
                     state_in = ST_MUL;
                  end
               end
               cde_pkg::OP_BYTE: begin
                  if (!str_mode || skip_ff) begin
                     ign_in = 1'b1;
                  end else begin
                     x_in     = acc_ff ^ {56'd0, byte_ff & cde_pkg::BYTE_MASK};
                     bidx_in  = LAST_LEN;
                     state_in = ST_MUL;
                  end
               end
               default: begin
                  ign_in = 1'b1;
               end
            endcase
         end

         ST_MUL: begin
            sum_in = unit_result;
            if (step_ff == LAST_STEP) begin
               step_in = '0;
               if (bidx_ff == LAST_LEN) begin
                  acc_in   = unit_result;
                  state_in = ST_EMIT;
               end else begin
                  // advance to the next length byte
                  bidx_in = bidx_next;
                  x_in    = unit_result ^ {56'd0, len_byte_next};
                  sum_in  = '0;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end

         ST_EMIT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_digest_in = acc_ff;
               rsp_ign_in    = ign_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= cde_pkg::COL_INT32;
         acc_ff       <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         acc_ff       <= acc_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      row_valid_ff  <= row_valid_in;
      value_ff      <= value_in;
      len_ff        <= len_in;
      byte_ff       <= byte_in;
      x_ff          <= x_in;
      sum_ff        <= sum_in;
      step_ff       <= step_in;
      bidx_ff       <= bidx_in;
      ign_ff        <= ign_in;
      rsp_digest_ff <= rsp_digest_in;
      rsp_ign_ff    <= rsp_ign_in;
   end

endmodule

`default_nettype wire

>>> hdl/cde_shift_add.sv
// Shared arithmetic unit: a plus or xor b shifted left by a selectable amount.
// Depends on cde_pkg for the control struct.
`default_nettype none

module cde_shift_add (
   input  wire logic [63:0]           a,
   input  wire logic [63:0]           b,
   input  wire cde_pkg::unit_ctrl_type ctrl,
   output logic [63:0]                result
);

   logic [63:0] b_shifted;

   always_comb begin
      b_shifted = b << ctrl.shift;
      if (ctrl.xor_mode) begin
         result = a ^ b_shifted;
      end else begin
         result = a + b_shifted;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cde_checker.sv
// Port-level assertions for column_digest_engine_core, attached by bind.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module cde_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_digest,
   input wire logic        rsp_item_ignored
);

   // a response waits until transferred
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_digest) && $stable(rsp_item_ignored))
      else $error("response payload changed while stalled");

   // one item at a time: busy right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   // a new response only comes out of a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without an item in flight");

endmodule

bind column_digest_engine_core cde_checker u_cde_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_digest       (rsp_chan.digest),
   .rsp_item_ignored (rsp_chan.item_ignored)
);

`default_nettype wire
